// ----- rtl/ptqi_pkg.sv -----
// ----------------------------------------------------------------------------
// ptqi_pkg
// Shared types, constants and stage functions of the periodic table
// interpolation unit.
// ----------------------------------------------------------------------------
package ptqi_pkg;

  // Default table depth.
  localparam int MaxPointsDef = 64;

  // Field widths.
  localparam int CountW = 7;
  localparam int SpanW  = 23;
  localparam int AngleW = 24;
  localparam int IdxW   = 6;
  localparam int ValW   = 24;
  localparam int SegW   = 7;
  localparam int FracW  = 16;

  // Pipeline shape of the fold and locate sections.
  localparam int FoldStages = 6;
  localparam int FoldBits   = 4;
  localparam int LocStages  = 7;

  // Configuration register indexes.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t RegEntryCount = 2'd0;
  localparam cfg_idx_t RegAngleSpan  = 2'd1;

  // Command codes.
  localparam logic CmdLookup = 1'b0;
  localparam logic CmdWrite  = 1'b1;

  typedef struct packed {
    logic                     command;
    logic signed [AngleW-1:0] angle;
    logic [IdxW-1:0]          entry_index;
    logic signed [ValW-1:0]   entry_value;
  } in_t;

  typedef struct packed {
    logic signed [ValW-1:0] correction;
    logic [IdxW-1:0]        segment;
  } out_t;

  // Item state carried through the fold and locate sections.
  typedef struct packed {
    logic                   wr;
    logic [IdxW-1:0]        idx;
    logic signed [ValW-1:0] val;
    logic                   dis;
    logic                   neg;
    logic [AngleW-1:0]      num;
    logic [29:0]            rem;
    logic [SegW-1:0]        seg;
    logic [FracW-1:0]       t;
  } tok_t;

  // Four restoring division steps of the angle magnitude by the span.
  function automatic tok_t fold_stage(tok_t a, logic [SpanW-1:0] span);
    tok_t        b;
    logic [23:0] r;
    b = a;
    for (int i = 0; i < FoldBits; i++) begin
      r     = {b.rem[22:0], b.num[23]};
      b.num = {b.num[22:0], 1'b0};
      if (r >= {1'b0, span}) begin
        r = r - {1'b0, span};
      end
      b.rem = {6'b0, r};
    end
    return b;
  endfunction

  // One stage of the locate section: sign fix and scaling, then the
  // segment quotient bits, then the fraction bits, four a stage.
  function automatic tok_t loc_stage(tok_t a, logic [SpanW-1:0] span,
                                     logic [CountW-1:0] n, int j);
    tok_t        b;
    logic [22:0] x;
    logic [29:0] d;
    logic [23:0] r;
    int          k;
    b = a;
    x = '0;
    d = '0;
    r = '0;
    k = 0;
    case (j)
      0: begin
        x = a.rem[22:0];
        if (a.neg && (a.rem[22:0] != '0)) begin
          x = span - a.rem[22:0];
        end
        b.rem = 30'(x) * 30'(n);
        b.seg = '0;
        b.t   = '0;
      end
      1, 2: begin
        for (int i = 0; i < 4; i++) begin
          k = (j == 1) ? 6 - i : 2 - i;
          if (k >= 0) begin
            d = 30'(span) << k;
            if (b.rem >= d) begin
              b.rem    = b.rem - d;
              b.seg[k] = 1'b1;
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          k = 15 - 4 * (j - 3) - i;
          r = {b.rem[22:0], 1'b0};
          if (r >= {1'b0, span}) begin
            r      = r - {1'b0, span};
            b.t[k] = 1'b1;
          end
          b.rem = 30'(r);
        end
      end
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/ptqi_ram.sv -----
// ----------------------------------------------------------------------------
// ptqi_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module ptqi_ram #(
  parameter int Width = 24,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ptqi_fold.sv -----
// ----------------------------------------------------------------------------
// ptqi_fold
// Pipelined restoring divider that reduces the angle magnitude modulo the span.
// ----------------------------------------------------------------------------
module ptqi_fold import ptqi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  tok_t             tok_i,
  input  logic [SpanW-1:0] span_i,
  output logic             valid_o,
  input  logic             ready_i,
  output tok_t             tok_o
);

  logic              valid_q [FoldStages];
  tok_t              data_q  [FoldStages];
  logic [FoldStages:0] rdy;

  assign rdy[FoldStages] = ready_i;

  for (genvar j = 0; j < FoldStages; j++) begin : g_stage
    logic vin;
    tok_t din;
    tok_t data_d;

    if (j == 0) begin : g_first
      assign vin = valid_i;
      assign din = tok_i;
    end else begin : g_next
      assign vin = valid_q[j-1];
      assign din = data_q[j-1];
    end

    // A stage takes a new item when it is empty or its item moves on.
    assign rdy[j]  = !valid_q[j] || rdy[j+1];
    assign data_d  = fold_stage(din, span_i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (rdy[j]) begin
        valid_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j] && vin) begin
        data_q[j] <= data_d;
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = valid_q[FoldStages-1];
  assign tok_o   = data_q[FoldStages-1];

endmodule

// ----- rtl/ptqi_locate.sv -----
// ----------------------------------------------------------------------------
// ptqi_locate
// Finds the segment index and the Q16 fraction inside the segment.
// ----------------------------------------------------------------------------
module ptqi_locate import ptqi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  tok_t              tok_i,
  input  logic [SpanW-1:0]  span_i,
  input  logic [CountW-1:0] count_i,
  output logic              valid_o,
  input  logic              ready_i,
  output tok_t              tok_o
);

  logic               valid_q [LocStages];
  tok_t               data_q  [LocStages];
  logic [LocStages:0] rdy;

  assign rdy[LocStages] = ready_i;

  for (genvar j = 0; j < LocStages; j++) begin : g_stage
    logic vin;
    tok_t din;
    tok_t data_d;

    if (j == 0) begin : g_first
      assign vin = valid_i;
      assign din = tok_i;
    end else begin : g_next
      assign vin = valid_q[j-1];
      assign din = data_q[j-1];
    end

    assign rdy[j] = !valid_q[j] || rdy[j+1];
    assign data_d = loc_stage(din, span_i, count_i, j);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (rdy[j]) begin
        valid_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j] && vin) begin
        data_q[j] <= data_d;
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = valid_q[LocStages-1];
  assign tok_o   = data_q[LocStages-1];

endmodule

// ----- rtl/ptqi_interp.sv -----
// ----------------------------------------------------------------------------
// ptqi_interp
// Table store, neighbour reads and the quadratic Lagrange arithmetic.
// ----------------------------------------------------------------------------
module ptqi_interp import ptqi_pkg::*; #(
  parameter int MaxPoints = MaxPointsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  tok_t              tok_i,
  input  logic [CountW-1:0] count_i,
  output logic              valid_o,
  input  logic              ready_i,
  output out_t              item_o
);

  localparam int AW = $clog2(MaxPoints);

  typedef struct packed {
    logic             dis;
    logic [SegW-1:0]  seg;
    logic [FracW-1:0] t;
  } sa_t;

  typedef struct packed {
    logic                   dis;
    logic [SegW-1:0]        seg;
    logic signed [ValW-1:0] p;
    logic signed [ValW-1:0] c;
    logic signed [ValW-1:0] q;
    logic signed [33:0]     ta;
    logic signed [33:0]     tb;
    logic signed [33:0]     td;
  } sb_t;

  typedef struct packed {
    logic               dis;
    logic [SegW-1:0]    seg;
    logic signed [57:0] pa;
    logic signed [57:0] cb;
    logic signed [57:0] qd;
  } sc_t;

  typedef struct packed {
    logic               dis;
    logic [SegW-1:0]    seg;
    logic signed [59:0] s;
  } sd_t;

  logic va_q, vb_q, vc_q, vd_q, ve_q;
  logic ra, rb, rc, rd, re;
  sa_t  a_q;
  sb_t  b_q, b_d;
  sc_t  c_q, c_d;
  sd_t  d_q, d_d;
  out_t e_q, e_d;

  logic [SegW-1:0]      prev_seg, next_seg;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        waddr;
  logic [ValW-1:0]      rd_p, rd_c, rd_q;
  logic [31:0]          tt;
  logic signed [59:0]   s_round;
  logic signed [26:0]   r_full;

  // Ready chain across the five stages.
  assign re = !ve_q || ready_i;
  assign rd = !vd_q || re;
  assign rc = !vc_q || rd;
  assign rb = !vb_q || rc;
  assign ra = !va_q || rb;
  assign ready_o = ra;

  // Wrapped neighbour indices of the segment.
  assign prev_seg = (tok_i.seg == '0) ? count_i - 1'b1 : tok_i.seg - 1'b1;
  assign next_seg = (tok_i.seg + 1'b1 == count_i) ? '0 : tok_i.seg + 1'b1;

  // Writes take effect in item order, at the point where lookups read.
  assign ram_we = valid_i && ra && (tok_i.wr == CmdWrite) &&
                  (32'(tok_i.idx) < MaxPoints);
  assign ram_re = valid_i && ra && (tok_i.wr == CmdLookup);
  assign waddr  = AW'(tok_i.idx);

  ptqi_ram #(.Width(ValW), .Depth(MaxPoints)) u_ram_prev (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(tok_i.val),
    .re_i   (ram_re),
    .raddr_i(AW'(prev_seg)),
    .rdata_o(rd_p)
  );

  ptqi_ram #(.Width(ValW), .Depth(MaxPoints)) u_ram_cur (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(tok_i.val),
    .re_i   (ram_re),
    .raddr_i(AW'(tok_i.seg)),
    .rdata_o(rd_c)
  );

  ptqi_ram #(.Width(ValW), .Depth(MaxPoints)) u_ram_next (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(tok_i.val),
    .re_i   (ram_re),
    .raddr_i(AW'(next_seg)),
    .rdata_o(rd_q)
  );

  // Lagrange basis terms in t, with U equal to one in Q16.
  always_comb begin
    tt       = 32'(a_q.t) * 32'(a_q.t);
    b_d.dis  = a_q.dis;
    b_d.seg  = a_q.seg;
    b_d.p    = $signed(rd_p);
    b_d.c    = $signed(rd_c);
    b_d.q    = $signed(rd_q);
    b_d.ta   = $signed({2'b00, tt}) - $signed({2'b00, a_q.t, 16'h0000});
    b_d.tb   = $signed({2'b00, tt}) - $signed({2'b01, 32'h0000_0000});
    b_d.td   = $signed({2'b00, tt}) + $signed({2'b00, a_q.t, 16'h0000});
  end

  // Weighted products of the three neighbours.
  always_comb begin
    c_d.dis = b_q.dis;
    c_d.seg = b_q.seg;
    c_d.pa  = 58'(b_q.p) * 58'(b_q.ta);
    c_d.cb  = 58'(b_q.c) * 58'(b_q.tb);
    c_d.qd  = 58'(b_q.q) * 58'(b_q.td);
  end

  // Sum of the weighted terms.
  always_comb begin
    d_d.dis = c_q.dis;
    d_d.seg = c_q.seg;
    d_d.s   = 60'(c_q.pa) - (60'(c_q.cb) <<< 1) + 60'(c_q.qd);
  end

  // Round half up at bit 33, saturate, and zero a disabled lookup.
  always_comb begin
    s_round = d_q.s + $signed(60'h0_0000_0001_0000_0000);
    r_full  = s_round[59:33];
    if (r_full > 27'sd8388607) begin
      e_d.correction = 24'sh7FFFFF;
    end else if (r_full < -27'sd8388608) begin
      e_d.correction = 24'sh800000;
    end else begin
      e_d.correction = r_full[23:0];
    end
    e_d.segment = d_q.seg[IdxW-1:0];
    if (d_q.dis) begin
      e_d.correction = '0;
      e_d.segment    = '0;
    end
  end

  // Stage valid bits; write items leave the pipeline at the table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (ra) va_q <= valid_i && (tok_i.wr == CmdLookup);
      if (rb) vb_q <= va_q;
      if (rc) vc_q <= vb_q;
      if (rd) vd_q <= vc_q;
      if (re) ve_q <= vd_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      a_q.dis <= tok_i.dis;
      a_q.seg <= tok_i.seg;
      a_q.t   <= tok_i.t;
    end
    if (rb && va_q) b_q <= b_d;
    if (rc && vb_q) c_q <= c_d;
    if (rd && vc_q) d_q <= d_d;
    if (re && vd_q) e_q <= e_d;
  end

  assign valid_o = ve_q;
  assign item_o  = e_q;

endmodule

// ----- rtl/periodic_table_quadratic_interp_unit.sv -----
// ----------------------------------------------------------------------------
// periodic_table_quadratic_interp_unit
// Periodic correction table with three-point quadratic Lagrange lookup.
//
//   Channel   Direction  Payload  Handshake
//   in        input      in_t     in_valid_i / in_ready_o
//   out       output     out_t    out_valid_o / out_ready_i
//   cfg       input      index    cfg_valid_i / cfg_ready_o (always ready)
//
// One item is taken every cycle while the pipeline is not stalled; a lookup
// passes through the 6 fold stages, the 7 locate stages and the 5 table and
// arithmetic stages. Write items leave no result. Reset clears both
// registers and all valid bits; the table is undefined until written.
// A stall at the output fills bubbles first, then holds every stage.
// ----------------------------------------------------------------------------
module periodic_table_quadratic_interp_unit import ptqi_pkg::*; #(
  parameter int MaxPoints = MaxPointsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_item_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  cfg_idx_t         cfg_index_i,
  input  logic [SpanW-1:0] cfg_data_i
);

  logic [CountW-1:0] count_q;
  logic [SpanW-1:0]  span_q;
  logic [CountW-1:0] n_eff;
  tok_t              tok_in, tok_fold, tok_loc;
  logic              fold_valid, fold_ready, loc_valid, loc_ready;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      span_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegEntryCount: count_q <= cfg_data_i[CountW-1:0];
        RegAngleSpan:  span_q  <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // Count in use, limited to the table depth.
  assign n_eff = (32'(count_q) > MaxPoints) ? CountW'(MaxPoints) : count_q;

  // Item state at entry.
  always_comb begin
    tok_in.wr  = in_item_i.command;
    tok_in.idx = in_item_i.entry_index;
    tok_in.val = in_item_i.entry_value;
    tok_in.dis = (n_eff < CountW'(3)) || (span_q == '0);
    tok_in.neg = in_item_i.angle[AngleW-1];
    tok_in.num = tok_in.neg ? AngleW'(-in_item_i.angle) : AngleW'(in_item_i.angle);
    tok_in.rem = '0;
    tok_in.seg = '0;
    tok_in.t   = '0;
  end

  ptqi_fold u_fold (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_i),
    .ready_o(in_ready_o),
    .tok_i  (tok_in),
    .span_i (span_q),
    .valid_o(fold_valid),
    .ready_i(fold_ready),
    .tok_o  (tok_fold)
  );

  ptqi_locate u_locate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(fold_valid),
    .ready_o(fold_ready),
    .tok_i  (tok_fold),
    .span_i (span_q),
    .count_i(n_eff),
    .valid_o(loc_valid),
    .ready_i(loc_ready),
    .tok_o  (tok_loc)
  );

  ptqi_interp #(.MaxPoints(MaxPoints)) u_interp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(loc_valid),
    .ready_o(loc_ready),
    .tok_i  (tok_loc),
    .count_i(n_eff),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .item_o (out_item_o)
  );

endmodule

// ----- rtl/ptqi_checker.sv -----
// ----------------------------------------------------------------------------
// ptqi_checker
// Port-level checks of the periodic table interpolation unit.
// ----------------------------------------------------------------------------
module ptqi_checker import ptqi_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input out_t             out_item_o,
  input logic             cfg_valid_i,
  input logic             cfg_ready_o,
  input cfg_idx_t         cfg_index_i,
  input logic [SpanW-1:0] cfg_data_i
);

  logic [CountW-1:0] count_q;

  // Shadow of the entry count as written through the port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i == RegEntryCount)) begin
      count_q <= cfg_data_i[CountW-1:0];
    end
  end

  // A held result stays unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // With the output empty, no stage can hold back the input.
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // The segment lies inside the configured table.
  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.segment == '0) ||
                    ({1'b0, out_item_o.segment} < count_q))
    else $error("segment outside table");

  // Too few points gives a zero result.
  a_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (count_q < CountW'(3)) |->
      (out_item_o.correction == '0) && (out_item_o.segment == '0))
    else $error("disabled lookup gave a non-zero result");

endmodule

bind periodic_table_quadratic_interp_unit ptqi_checker u_ptqi_checker (.*);

// ----- verif/periodic_table_quadratic_interp_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_table_quadratic_interp_unit_tb
// Drives table writes and angle lookups through the item channel. Each
// lookup's correction and segment are predicted here, checked in order
// against the output channel, and the run is repeated over several
// table sizes and spans, including the extremes, with and without random idling.
// ----------------------------------------------------------------------------
module periodic_table_quadratic_interp_unit_tb;
  import ptqi_pkg::*;

  localparam int TablePoints = 64;
  localparam int Latency     = 18;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  in_t              in_item_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_t             out_item_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  cfg_idx_t         cfg_index_i;
  logic [SpanW-1:0] cfg_data_i;

  periodic_table_quadratic_interp_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Predictor state: the table, which entries hold data, and the registers.
  logic signed [ValW-1:0] table_mirror [TablePoints];
  bit                     entry_known  [TablePoints];
  logic [CountW-1:0]      count_reg;
  logic [SpanW-1:0]       span_reg;

  out_t corrections_due [$];
  int   fail_count;
  int   send_idle_pct;
  int   recv_idle_pct;

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Expected result of one lookup.
  function automatic out_t interpolate(logic signed [AngleW-1:0] ang);
    out_t        r;
    longint      n, span, x, seg, rem, t, p, c, q, s, v;
    r = '0;
    n = (count_reg > TablePoints) ? TablePoints : count_reg;
    span = span_reg;
    if (n < 3 || span == 0) return r;
    x = longint'(ang) % span;
    if (x < 0) x += span;
    seg = (x * n) / span;
    if (seg >= n) seg = n - 1;
    rem = x * n - seg * span;
    t = (rem * 65536) / span;
    p = table_mirror[(seg + n - 1) % n];
    c = table_mirror[seg];
    q = table_mirror[(seg + 1) % n];
    s = p * (t * (t - 65536)) - 2 * c * ((t + 65536) * (t - 65536))
        + q * (t * (t + 65536));
    // Arithmetic shift gives the floor division by 2^33.
    v = (s + (64'sd1 <<< 32)) >>> 33;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    r.correction = v[23:0];
    r.segment    = seg[5:0];
    return r;
  endfunction

  // True when every entry a lookup could read has been written.
  function automatic bit table_ready();
    int n;
    n = (count_reg > TablePoints) ? TablePoints : count_reg;
    for (int i = 0; i < n; i++) if (!entry_known[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Send one item, holding it until accepted. Valid stays high into the
  // next item unless the sender idles or the stream is drained.
  task automatic send_item(in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (it.command == CmdWrite) begin
      table_mirror[it.entry_index] = it.entry_value;
      entry_known[it.entry_index]  = 1'b1;
    end else begin
      corrections_due.push_back(interpolate(it.angle));
    end
    @(negedge clk_i);
  endtask

  task automatic write_entry(int idx, logic signed [ValW-1:0] val);
    in_t it;
    it = '0;
    it.command     = CmdWrite;
    it.entry_index = idx[5:0];
    it.entry_value = val;
    it.angle       = 24'($urandom);
    send_item(it);
  endtask

  task automatic lookup(logic signed [AngleW-1:0] ang);
    in_t it;
    it = '0;
    it.command     = CmdLookup;
    it.angle       = ang;
    it.entry_index = 6'($urandom);
    it.entry_value = 24'($urandom);
    send_item(it);
  endtask

  // Stop sending and wait until the pipeline has emptied, with a margin
  // for write items.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (corrections_due.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  // Register write, only from an idle block.
  task automatic write_reg(cfg_idx_t idx, logic [SpanW-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == RegEntryCount) count_reg = data[CountW-1:0];
    else if (idx == RegAngleSpan) span_reg = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (corrections_due.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, out_item_o);
        fail_count++;
      end else begin
        e = corrections_due.pop_front();
        if (out_item_o.correction !== e.correction)
          begin
          $display("%0t correction mismatch: expected %0d, actual %0d", $time,
                   e.correction, out_item_o.correction);
          fail_count++;
        end
        if (out_item_o.segment !== e.segment) begin
          $display("%0t segment mismatch: expected %0d, actual %0d", $time,
                   e.segment, out_item_o.segment);
          fail_count++;
        end
      end
    end
  end

  // Receiver stalls.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic fill_table(int mode);
    for (int i = 0; i < TablePoints; i++) begin
      case (mode)
        0: write_entry(i, (i % 2) ? 24'sh7FFFFF : -24'sh800000);
        default: write_entry(i, 24'($urandom));
      endcase
    end
  endtask

  // Lookups with the table and registers disabled.
  task automatic test_disabled();
    lookup(24'sh7FFFFF);
    lookup(-24'sh800000);
    write_reg(RegEntryCount, 23'd2);
    write_reg(RegAngleSpan, 23'd1000);
    lookup(24'sd12345);
    write_reg(RegEntryCount, 23'd8);
    write_reg(RegAngleSpan, 23'd0);
    lookup(24'sd12345);
  endtask

  // Extremes of angles and values against a full table.
  task automatic test_directed();
    fill_table(0);
    write_reg(RegEntryCount, 23'd64);
    write_reg(RegAngleSpan, 23'h7FFFFF);
    lookup(24'sh7FFFFF);
    lookup(-24'sh800000);
    lookup(24'sd0);
    lookup(-24'sd1);
    write_reg(RegEntryCount, 23'd127);
    lookup(24'sh400000);
    lookup(-24'sh400001);
    write_reg(RegEntryCount, 23'd3);
    write_reg(RegAngleSpan, 23'd1);
    lookup(24'sd5);
    write_reg(RegAngleSpan, 23'd3);
    lookup(-24'sd7);
    lookup(24'sd2);
  endtask

  // Random traffic over one register setting.
  task automatic test_random(int count, int span, int items);
    write_reg(RegEntryCount, count[22:0]);
    write_reg(RegAngleSpan, span[22:0]);
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(9) == 0)
        write_entry($urandom_range(TablePoints - 1), 24'($urandom));
      else if ($urandom_range(3) == 0)
        lookup($urandom_range(span * 3) - span);
      else
        lookup(24'($urandom));
      if (k == items / 2) drain();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegEntryCount;
    cfg_data_i  = '0;
    count_reg   = '0;
    span_reg    = '0;
    fail_count  = 0;
    send_idle_pct = 7;
    recv_idle_pct = 76;
    foreach (entry_known[i]) entry_known[i] = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_disabled();
    test_directed();
    fill_table(1);
    test_random(64, 8388607, 110);
    test_random(5, 411775, 110);
    send_idle_pct = 76;
    recv_idle_pct = 7;
    test_random(3, 65536 * 6, 110);
    test_random(100, 2, 110);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(17, $urandom_range(8388607, 1), 120);
    test_random(64, 411774, 120);
    drain();

    if (fail_count == 0 && corrections_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
